// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define WHSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("whsd assertion failed");

// Check a property on every rising clock edge, reset included.
`define WHSD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("whsd assertion failed");

`endif

// ===== rtl/whsd_pkg.sv =====
package whsd_pkg;

   // Window geometry; WINDOW is a power of two so the means reduce to shifts.
   localparam int unsigned WINDOW      = 16;
   localparam int unsigned HALF_WINDOW = WINDOW / 2;
   localparam int unsigned PTR_W       = $clog2(WINDOW);
   localparam int unsigned HALF_SHIFT  = PTR_W - 1;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned THR_W    = 16;
   // Running sums hold up to WINDOW full-scale samples.
   localparam int unsigned SUM_W    = SAMPLE_W + PTR_W;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_class_type;

   // Signed divide by 2**shift, truncating toward zero.
   function automatic logic signed [SAMPLE_W-1:0] div_pow2(
      input logic signed [SUM_W-1:0] value,
      input int unsigned             shift
   );
      logic signed [SUM_W-1:0] bias;
      logic signed [SUM_W-1:0] biased;
      logic signed [SUM_W-1:0] shifted;
      bias    = value[SUM_W-1] ? SUM_W'((1 << shift) - 1) : '0;
      biased  = value + bias;
      shifted = biased >>> shift;
      return shifted[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== rtl/whsd_ram.sv =====
module whsd_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write one entry, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/window_half_step_detector.sv =====
// Channel    Ports                           Direction   Handshake
// req        req_sample                      in          req_valid / req_stall
// rsp        rsp_*_mean, rsp_edge_class      out         rsp_valid / rsp_stall
// csr        csr_edge_threshold              in          csr_valid / csr_ready
//
// A sample is not accepted while the one before still updates the sums: the
// cycle after accept the sample RAM returns the overwritten and middle entries
// and the sums update; once the output register is free the means load into it
// as a new sample may be taken. The single RAM's read-then-write pass sets this.
// Synchronous reset clears pointer, entry valid bits, sums and threshold.
// A stalled result holds; one more sample may be in flight behind it.
module window_half_step_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [whsd_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_window_mean,
   output logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_older_mean,
   output logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_recent_mean,
   output whsd_pkg::edge_class_type              rsp_edge_class,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [whsd_pkg::THR_W-1:0]            csr_edge_threshold
);

   import whsd_pkg::*;

   logic                        req_accept;
   logic                        out_load;
   logic [PTR_W-1:0]            mid_addr;
   logic [SAMPLE_W-1:0]         rd_old;
   logic [SAMPLE_W-1:0]         rd_mid;
   logic signed [SUM_W-1:0]     x_old;
   logic signed [SUM_W-1:0]     x_mid;
   logic signed [SUM_W-1:0]     x_new;

   logic [PTR_W-1:0]            wp_ff, wp_in;
   logic [WINDOW-1:0]           vld_ff, vld_in;
   logic                        s1_ff, s1_in;
   logic                        s2_ff, s2_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                        old_vld_ff, old_vld_in;
   logic                        mid_vld_ff, mid_vld_in;
   logic signed [SUM_W-1:0]     older_ff, older_in;
   logic signed [SUM_W-1:0]     recent_ff, recent_in;
   logic signed [SUM_W-1:0]     total_ff, total_in;
   logic [THR_W-1:0]            thr_ff, thr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  wmean_ff, wmean_in;
   logic signed [SAMPLE_W-1:0]  omean_ff, omean_in;
   logic signed [SAMPLE_W-1:0]  rmean_ff, rmean_in;
   edge_class_type              class_ff, class_in;

   logic signed [SAMPLE_W+1:0]  diff;
   logic signed [SAMPLE_W+1:0]  thr_pos;
   logic signed [SAMPLE_W+1:0]  thr_neg;

   // Handshakes: take a sample only when the sums are free next cycle
   assign out_load   = s2_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_ff || (s2_ff && !out_load);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign mid_addr   = wp_ff + PTR_W'(HALF_WINDOW);

   whsd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (s1_ff),
      .wr_addr   (wp_ff),
      .wr_data   (sample_ff),
      .rd_en     (req_accept),
      .rd_addr_a (wp_ff),
      .rd_data_a (rd_old),
      .rd_addr_b (mid_addr),
      .rd_data_b (rd_mid)
   );

   // Never-written entries read as zero
   assign x_old = old_vld_ff ? SUM_W'($signed(rd_old)) : '0;
   assign x_mid = mid_vld_ff ? SUM_W'($signed(rd_mid)) : '0;
   assign x_new = SUM_W'(sample_ff);

   // Edge decision from the half means
   always_comb begin
      diff    = (SAMPLE_W+2)'(rmean_in) - (SAMPLE_W+2)'(omean_in);
      thr_pos = $signed({2'b00, thr_ff});
      thr_neg = -thr_pos;
   end

   // Next state: capture, update sums, load result
   always_comb begin
      wp_in        = wp_ff;
      vld_in       = vld_ff;
      s1_in        = req_accept;
      s2_in        = s2_ff;
      sample_in    = sample_ff;
      old_vld_in   = old_vld_ff;
      mid_vld_in   = mid_vld_ff;
      older_in     = older_ff;
      recent_in    = recent_ff;
      total_in     = total_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      wmean_in     = div_pow2(total_ff, PTR_W);
      omean_in     = div_pow2(older_ff, HALF_SHIFT);
      rmean_in     = div_pow2(recent_ff, HALF_SHIFT);
      class_in     = class_ff;

      if (csr_valid) begin
         thr_in = csr_edge_threshold;
      end

      // Capture the sample and the valid bits of the two entries read
      if (req_accept) begin
         sample_in  = req_sample;
         old_vld_in = vld_ff[wp_ff];
         mid_vld_in = vld_ff[mid_addr];
      end

      // Slide both halves by one entry and write the new sample
      if (s1_ff) begin
         older_in      = older_ff - x_old + x_mid;
         recent_in     = recent_ff - x_mid + x_new;
         total_in      = total_ff - x_old + x_new;
         vld_in[wp_ff] = 1'b1;
         wp_in         = wp_ff + PTR_W'(1);
         s2_in         = 1'b1;
      end else if (out_load) begin
         s2_in = 1'b0;
      end

      // Output register: load a fresh result or drop a taken one
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (diff > thr_pos) begin
            class_in = EDGE_RISE;
         end else if (diff < thr_neg) begin
            class_in = EDGE_FALL;
         end else begin
            class_in = EDGE_NONE;
         end
      end else begin
         wmean_in = wmean_ff;
         omean_in = omean_ff;
         rmean_in = rmean_ff;
         if (!rsp_stall) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         vld_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         older_ff     <= '0;
         recent_ff    <= '0;
         total_ff     <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         vld_ff       <= vld_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         older_ff     <= older_in;
         recent_ff    <= recent_in;
         total_ff     <= total_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      old_vld_ff <= old_vld_in;
      mid_vld_ff <= mid_vld_in;
      wmean_ff   <= wmean_in;
      omean_ff   <= omean_in;
      rmean_ff   <= rmean_in;
      class_ff   <= class_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_mean = wmean_ff;
   assign rsp_older_mean  = omean_ff;
   assign rsp_recent_mean = rmean_ff;
   assign rsp_edge_class  = class_ff;

endmodule

// ===== rtl/whsd_checker.sv =====
`include "assert_macros.svh"

module whsd_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_window_mean,
   input  logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_older_mean,
   input  logic signed [whsd_pkg::SAMPLE_W-1:0]  rsp_recent_mean,
   input  whsd_pkg::edge_class_type              rsp_edge_class
);

   import whsd_pkg::*;

   // No result survives reset
   `WHSD_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // No accept right after an accept
   `WHSD_ASSERT(a_no_back_to_back, clock, reset, (req_valid && !req_stall) |=> req_stall)

   // A rise means the recent half mean is above the older one
   `WHSD_ASSERT(a_rise_order, clock, reset, (rsp_valid && rsp_edge_class == EDGE_RISE) |-> (rsp_recent_mean > rsp_older_mean))

   // A fall means the recent half mean is below the older one
   `WHSD_ASSERT(a_fall_order, clock, reset, (rsp_valid && rsp_edge_class == EDGE_FALL) |-> (rsp_recent_mean < rsp_older_mean))

   // A stalled result holds
   `WHSD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_window_mean) && $stable(rsp_edge_class)))

endmodule

bind window_half_step_detector whsd_checker u_whsd_checker (.*);

// ===== verif/window_half_step_detector_test.sv =====
`timescale 1ns / 100ps

module window_half_step_detector_test;
   import whsd_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] window_mean;
      logic signed [SAMPLE_W-1:0] older_mean;
      logic signed [SAMPLE_W-1:0] recent_mean;
      edge_class_type             edge_class;
   } mean_report_type;

   // Mirror of the sample window; predicts one mean report per accepted sample
   class mean_edge_board_type;
      logic signed [SAMPLE_W-1:0] window_store [WINDOW];
      int unsigned                oldest;
      logic [THR_W-1:0]           threshold;
      mean_report_type            expected_reports [$];
      int                         failures;

      function new();
         foreach (window_store[i]) window_store[i] = '0;
         oldest    = 0;
         threshold = '0;
         failures  = 0;
      endfunction

      function void set_threshold(logic [THR_W-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      // Overwrite the oldest entry, advance, then work out the three means and the edge
      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         int              total;
         int              older_sum;
         int              recent_sum;
         int              older;
         int              recent;
         int              spread;
         mean_report_type report;
         window_store[oldest] = sample;
         oldest = (oldest + 1) % WINDOW;
         total      = 0;
         older_sum  = 0;
         recent_sum = 0;
         for (int i = 0; i < WINDOW; i++) total += window_store[i];
         for (int i = 0; i < HALF_WINDOW; i++) begin
            older_sum  += window_store[(oldest + i) % WINDOW];
            recent_sum += window_store[(oldest + HALF_WINDOW + i) % WINDOW];
         end
         older  = (older_sum * 2) / int'(WINDOW);
         recent = (recent_sum * 2) / int'(WINDOW);
         spread = recent - older;
         if (spread < 0) spread = -spread;
         report.window_mean = SAMPLE_W'(total / int'(WINDOW));
         report.older_mean  = SAMPLE_W'(older);
         report.recent_mean = SAMPLE_W'(recent);
         report.edge_class  = EDGE_NONE;
         if (spread > int'(threshold))
            report.edge_class = (recent > older) ? EDGE_RISE : EDGE_FALL;
         expected_reports.push_back(report);
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_report(logic signed [SAMPLE_W-1:0] window_mean,
                                 logic signed [SAMPLE_W-1:0] older_mean,
                                 logic signed [SAMPLE_W-1:0] recent_mean,
                                 edge_class_type edge_class);
         mean_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result: window_mean %0d older_mean %0d recent_mean %0d edge %0d",
                     $time, window_mean, older_mean, recent_mean, edge_class);
            failures++;
            return;
         end
         want = expected_reports.pop_front();
         if (window_mean !== want.window_mean) begin
            $display("%0t: window_mean expected %0d actual %0d",
                     $time, want.window_mean, window_mean);
            failures++;
         end
         if (older_mean !== want.older_mean) begin
            $display("%0t: older_mean expected %0d actual %0d",
                     $time, want.older_mean, older_mean);
            failures++;
         end
         if (recent_mean !== want.recent_mean) begin
            $display("%0t: recent_mean expected %0d actual %0d",
                     $time, want.recent_mean, recent_mean);
            failures++;
         end
         if (edge_class !== want.edge_class) begin
            $display("%0t: edge_class expected %0d actual %0d",
                     $time, want.edge_class, edge_class);
            failures++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_window_mean;
   logic signed [SAMPLE_W-1:0] rsp_older_mean;
   logic signed [SAMPLE_W-1:0] rsp_recent_mean;
   edge_class_type             rsp_edge_class;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [THR_W-1:0]           csr_edge_threshold = '0;

   mean_edge_board_type board;
   int                  burst_left = 1;
   int                  stall_mode = 0;
   int                  stall_left = 0;

   window_half_step_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_mean    (rsp_window_mean),
      .rsp_older_mean     (rsp_older_mean),
      .rsp_recent_mean    (rsp_recent_mean),
      .rsp_edge_class     (rsp_edge_class),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_edge_threshold (csr_edge_threshold)
   );

   always #2 clock = ~clock;

   // Present one sample, hold it until accepted, then close the burst or keep going
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      board.note_sample(value);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register transaction on the csr channel
   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_edge_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_threshold(value);
   endtask

   // Check accepted results, then pick the next stall level
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_window_mean, rsp_older_mean, rsp_recent_mean, rsp_edge_class);
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 4) != 0);
         default: rsp_stall <= ((stall_left % 5) < 3);
      endcase
   end

   initial begin
      #2000000;
      $display("window_half_step_detector test failed");
      $finish;
   end

   initial begin
      logic signed [SAMPLE_W-1:0] corner_list [9];
      logic [THR_W-1:0]           phase_threshold;
      int                         level;
      int                         value;
      int                         spread;
      int                         run_left;
      int                         pick;
      board = new();
      corner_list = '{16'sh0000, -16'sh0001, 16'sh0001, 16'sh7FFF, -16'sh8000,
                      16'sh5555, -16'sh5556, 16'sh7FFE, -16'sh7FFF};
      level    = 0;
      spread   = 0;
      run_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Startup with zeros in the window, full-scale rise, full-scale fall, corners
      for (int i = 0; i < 8; i++) send_sample(16'sh7FFF);
      for (int i = 0; i < 8; i++) send_sample(-16'sh8000);
      foreach (corner_list[i]) send_sample(corner_list[i]);
      drain_results();

      // Random step sequences under a range of thresholds, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: phase_threshold = 16'hFFFF;
            1: phase_threshold = 16'h0001;
            2: phase_threshold = THR_W'($urandom_range(0, 255));
            3: phase_threshold = THR_W'($urandom);
            4: phase_threshold = 16'h0000;
            default: phase_threshold = THR_W'($urandom_range(0, 2000));
         endcase
         write_threshold(phase_threshold);
         for (int n = 0; n < 275; n++) begin
            if (run_left == 0) begin
               case ($urandom_range(0, 3))
                  0: level = int'($urandom_range(0, 65535)) - 32768;
                  1: level = 32767;
                  2: level = -32768;
                  default: level = int'($urandom_range(0, 2000)) - 1000;
               endcase
               run_left = $urandom_range(4, 24);
               spread   = $urandom_range(0, 300);
            end
            run_left--;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               value = level + int'($urandom_range(0, 2 * spread)) - spread;
               if (value > 32767) value = 32767;
               if (value < -32768) value = -32768;
            end else if (pick < 9) begin
               value = int'($urandom_range(0, 65535)) - 32768;
            end else begin
               value = int'(corner_list[$urandom_range(0, 8)]);
            end
            send_sample(SAMPLE_W'(value));
         end
         drain_results();
      end

      if (board.failures == 0)
         $display("window_half_step_detector test passed");
      else
         $display("window_half_step_detector test failed");
      $finish;
   end

endmodule
